>>> src/fixed_block_pool_allocator_assert.svh
// Assertion macros for the fixed block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FBPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");

// next-cycle implication, disabled in reset
`define FBPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");

`endif

>>> src/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam int ROW_BITS       = 16;
    localparam int ROW_SHIFT      = 4;
    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 17;
    localparam int EFF_SIZE_W     = 18;
    localparam int NBLK_W         = 9;
    localparam int STATUS_W       = 3;
    localparam int INDEX_W        = 8;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    localparam logic [ADDR_W-1:0] BASE_RESET  = 32'd0;
    localparam logic [SIZE_W-1:0] SIZE_RESET  = 17'd64;
    localparam logic [NBLK_W-1:0] COUNT_RESET = 9'd256;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_MISALIGN = 3'd3,
        ST_FREE     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_MUL,
        S_A_FIN,
        S_F_SPAN,
        S_F_RANGE,
        S_F_DIV,
        S_F_RD,
        S_F_CHK
    } state_t;

    typedef struct packed {
        logic    clr_write;
        logic    load;
        logic    row_next;
        logic    rd_alloc;
        logic    alloc_write;
        logic    div_init;
        logic    div_step;
        logic    rd_free;
        logic    free_write;
        logic    res_load;
        status_t res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic found;
        logic last_row;
        logic out_range;
        logic div_last;
        logic misaligned;
        logic bit_used;
    } dp_stat_t;

endpackage

>>> src/fbpa_ctrl.sv
// Request sequencing state machine of the fixed block pool allocator
module fbpa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                func,
    input  fbpa_pkg::dp_stat_t  stat,
    output fbpa_pkg::dp_cmd_t   cmd,
    output logic                busy
);

    fbpa_pkg::state_t state_reg;
    fbpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbpa_pkg::S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = fbpa_pkg::S_IDLE;
                end
            end
            fbpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = (func == fbpa_pkg::FUNC_FREE) ? fbpa_pkg::S_F_SPAN
                                                               : fbpa_pkg::S_A_RD;
                end
            end
            fbpa_pkg::S_A_RD:
            begin
                state_next = fbpa_pkg::S_A_CHK;
            end
            fbpa_pkg::S_A_CHK:
            begin
                if (stat.found)
                begin
                    state_next = fbpa_pkg::S_A_MUL;
                end
                else if (stat.last_row)
                begin
                    state_next = fbpa_pkg::S_IDLE;
                end
                else
                begin
                    state_next = fbpa_pkg::S_A_RD;
                end
            end
            fbpa_pkg::S_A_MUL:
            begin
                state_next = fbpa_pkg::S_A_FIN;
            end
            fbpa_pkg::S_A_FIN:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
            fbpa_pkg::S_F_SPAN:
            begin
                state_next = fbpa_pkg::S_F_RANGE;
            end
            fbpa_pkg::S_F_RANGE:
            begin
                state_next = stat.out_range ? fbpa_pkg::S_IDLE : fbpa_pkg::S_F_DIV;
            end
            fbpa_pkg::S_F_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = fbpa_pkg::S_F_RD;
                end
            end
            fbpa_pkg::S_F_RD:
            begin
                state_next = stat.misaligned ? fbpa_pkg::S_IDLE : fbpa_pkg::S_F_CHK;
            end
            fbpa_pkg::S_F_CHK:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = fbpa_pkg::ST_OK;
        unique case (state_reg)
            fbpa_pkg::S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
            end
            fbpa_pkg::S_IDLE:
            begin
                cmd.load = start;
            end
            fbpa_pkg::S_A_RD:
            begin
                cmd.rd_alloc = 1'b1;
            end
            fbpa_pkg::S_A_CHK:
            begin
                if (stat.found)
                begin
                    cmd.alloc_write = 1'b1;
                end
                else if (stat.last_row)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fbpa_pkg::ST_FULL;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                end
            end
            fbpa_pkg::S_A_MUL:
            begin
                cmd.res_status = fbpa_pkg::ST_OK;
            end
            fbpa_pkg::S_A_FIN:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = fbpa_pkg::ST_OK;
            end
            fbpa_pkg::S_F_SPAN:
            begin
                cmd.res_status = fbpa_pkg::ST_OK;
            end
            fbpa_pkg::S_F_RANGE:
            begin
                if (stat.out_range)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fbpa_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                end
            end
            fbpa_pkg::S_F_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            fbpa_pkg::S_F_RD:
            begin
                if (stat.misaligned)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fbpa_pkg::ST_MISALIGN;
                end
                else
                begin
                    cmd.rd_free = 1'b1;
                end
            end
            fbpa_pkg::S_F_CHK:
            begin
                cmd.res_load = 1'b1;
                if (stat.bit_used)
                begin
                    cmd.free_write = 1'b1;
                    cmd.res_status = fbpa_pkg::ST_OK;
                end
                else
                begin
                    cmd.res_status = fbpa_pkg::ST_FREE;
                end
            end
            default:
            begin
                cmd.res_status = fbpa_pkg::ST_OK;
            end
        endcase
    end

    assign busy = (state_reg != fbpa_pkg::S_IDLE);

endmodule

>>> src/fbpa_dp.sv
// Datapath of the fixed block pool allocator: registers, bitmap, divider, results
module fbpa_dp
#(
    parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  fbpa_pkg::dp_cmd_t                  cmd,
    output fbpa_pkg::dp_stat_t                 stat,
    input  logic                               func,
    input  logic [fbpa_pkg::ADDR_W-1:0]        address,
    input  logic                               cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_data,
    output logic                               done,
    output logic [fbpa_pkg::STATUS_W-1:0]      status,
    output logic [fbpa_pkg::ADDR_W-1:0]        block_address,
    output logic [fbpa_pkg::INDEX_W-1:0]       slot_index
);

    localparam int IDXW   = $clog2(MAX_BLOCKS);
    localparam int CW     = $clog2(MAX_BLOCKS + 1);
    localparam int ROWS   = (MAX_BLOCKS + fbpa_pkg::ROW_BITS - 1) / fbpa_pkg::ROW_BITS;
    localparam int RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STEP_W = $clog2(IDXW);
    localparam int PROD_W = IDXW + fbpa_pkg::EFF_SIZE_W;
    localparam int SPAN_W = CW + fbpa_pkg::EFF_SIZE_W;
    localparam int AW     = fbpa_pkg::ADDR_W;
    localparam int RB     = fbpa_pkg::ROW_BITS;

    logic [AW-1:0]                   base_reg;
    logic [fbpa_pkg::SIZE_W-1:0]     bsize_reg;
    logic [fbpa_pkg::NBLK_W-1:0]     nblk_reg;

    logic [RAW-1:0]                  clr_row_reg;
    logic [RAW-1:0]                  row_reg;
    logic                            res_valid_reg;

    logic                            func_reg;
    logic [AW-1:0]                   addr_reg;
    logic [IDXW-1:0]                 idx_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic [SPAN_W-1:0]               span_reg;
    logic [AW:0]                     off_reg;
    logic [AW-1:0]                   rem_reg;
    logic [AW-1:0]                   den_reg;
    logic [IDXW-1:0]                 q_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [RB-1:0]                   rd_data_reg;
    logic [fbpa_pkg::STATUS_W-1:0]   res_status_reg;
    logic [AW-1:0]                   res_addr_reg;
    logic [fbpa_pkg::INDEX_W-1:0]    res_idx_reg;

    logic [RB-1:0]                   map_mem [ROWS];

    logic [fbpa_pkg::EFF_SIZE_W-1:0] size_sum;
    logic [fbpa_pkg::EFF_SIZE_W-1:0] eff_size;
    logic [CW-1:0]                   eff_count;
    logic [31:0]                     row_base;
    logic [RB-1:0]                   avail;
    logic [fbpa_pkg::ROW_SHIFT-1:0]  pos;
    logic [fbpa_pkg::ROW_SHIFT-1:0]  bit_sel;
    logic [RAW-1:0]                  free_row;
    logic                            div_ge;
    logic                            rd_en;
    logic [RAW-1:0]                  rd_addr;
    logic                            wr_en;
    logic [RAW-1:0]                  wr_addr;
    logic [RB-1:0]                   wr_data;
    logic                            res_ok;

    always_comb
    begin
        size_sum = {1'b0, bsize_reg} + fbpa_pkg::EFF_SIZE_W'(7);
        eff_size = {size_sum[fbpa_pkg::EFF_SIZE_W-1:3], 3'b000};
        if (eff_size == '0)
        begin
            eff_size = fbpa_pkg::EFF_SIZE_W'(8);
        end
        if (32'(nblk_reg) > 32'(MAX_BLOCKS))
        begin
            eff_count = CW'(MAX_BLOCKS);
        end
        else
        begin
            eff_count = CW'(nblk_reg);
        end
    end

    always_comb
    begin
        row_base = 32'(row_reg) << fbpa_pkg::ROW_SHIFT;
        for (int j = 0; j < RB; j++)
        begin
            avail[j] = ((row_base + 32'(j)) < 32'(eff_count)) && !rd_data_reg[j];
        end
        pos = '0;
        for (int j = RB - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                pos = fbpa_pkg::ROW_SHIFT'(j);
            end
        end
    end

    assign bit_sel  = fbpa_pkg::ROW_SHIFT'(q_reg);
    assign free_row = RAW'(q_reg >> fbpa_pkg::ROW_SHIFT);
    assign div_ge   = (rem_reg >= den_reg);

    assign stat.clr_last   = (32'(clr_row_reg) == 32'(ROWS - 1));
    assign stat.found      = |avail;
    assign stat.last_row   = ((row_base + 32'(RB)) >= 32'(eff_count));
    assign stat.out_range  = off_reg[AW] || (64'(off_reg[AW-1:0]) >= 64'(span_reg));
    assign stat.div_last   = (step_reg == '0);
    assign stat.misaligned = (rem_reg != '0);
    assign stat.bit_used   = rd_data_reg[bit_sel];

    always_comb
    begin
        rd_en   = cmd.rd_alloc || cmd.rd_free;
        rd_addr = cmd.rd_free ? free_row : row_reg;
        wr_en   = cmd.clr_write || cmd.alloc_write || cmd.free_write;
        wr_addr = clr_row_reg;
        wr_data = '0;
        if (cmd.alloc_write)
        begin
            wr_addr = row_reg;
            wr_data = rd_data_reg | (RB'(1) << pos);
        end
        else if (cmd.free_write)
        begin
            wr_addr = free_row;
            wr_data = rd_data_reg & ~(RB'(1) << bit_sel);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= fbpa_pkg::BASE_RESET;
            bsize_reg     <= fbpa_pkg::SIZE_RESET;
            nblk_reg      <= fbpa_pkg::COUNT_RESET;
            clr_row_reg   <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fbpa_pkg::REG_BASE:  base_reg  <= cfg_data;
                    fbpa_pkg::REG_SIZE:  bsize_reg <= cfg_data[fbpa_pkg::SIZE_W-1:0];
                    fbpa_pkg::REG_COUNT: nblk_reg  <= cfg_data[fbpa_pkg::NBLK_W-1:0];
                    default:             base_reg  <= base_reg;
                endcase
            end
            if (cmd.clr_write)
            begin
                clr_row_reg <= clr_row_reg + RAW'(1);
            end
            if (cmd.load)
            begin
                row_reg <= '0;
            end
            else if (cmd.row_next)
            begin
                row_reg <= row_reg + RAW'(1);
            end
            res_valid_reg <= cmd.res_load;
        end
    end

    assign res_ok = (cmd.res_status == fbpa_pkg::ST_OK);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(idx_reg) * PROD_W'(eff_size);
        span_reg <= SPAN_W'(eff_count) * SPAN_W'(eff_size);
        off_reg  <= {1'b0, addr_reg} - {1'b0, base_reg};
        if (cmd.load)
        begin
            func_reg <= func;
            addr_reg <= address;
        end
        if (cmd.alloc_write)
        begin
            idx_reg <= IDXW'(row_base + 32'(pos));
        end
        if (cmd.div_init)
        begin
            rem_reg  <= off_reg[AW-1:0];
            den_reg  <= AW'(eff_size) << (IDXW - 1);
            q_reg    <= '0;
            step_reg <= STEP_W'(IDXW - 1);
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            den_reg  <= den_reg >> 1;
            q_reg    <= IDXW'({q_reg, div_ge});
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            if (res_ok && (func_reg == fbpa_pkg::FUNC_ALLOC))
            begin
                res_addr_reg <= base_reg + AW'(prod_reg);
            end
            else
            begin
                res_addr_reg <= '0;
            end
            if (!res_ok)
            begin
                res_idx_reg <= '0;
            end
            else if (func_reg == fbpa_pkg::FUNC_ALLOC)
            begin
                res_idx_reg <= fbpa_pkg::INDEX_W'(idx_reg);
            end
            else
            begin
                res_idx_reg <= fbpa_pkg::INDEX_W'(q_reg);
            end
        end
    end

    assign done          = res_valid_reg;
    assign status        = res_status_reg;
    assign block_address = res_addr_reg;
    assign slot_index    = res_idx_reg;

endmodule

>>> src/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator
// Allocate: scans 16-block bitmap rows, reading then checking each row, until a free block
// is found (then multiplies the index by the block size) or the last row is reached; free:
// checks the offset range, then finds the slot with the one-bit-per-cycle offset divider.
// One request at a time; the next is accepted while done pulses. After reset the bitmap is
// cleared one row per cycle with busy high; configuration resets to base 0, size 64, count 256.
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator
#(
    parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic [fbpa_pkg::ADDR_W-1:0]        address,
    output logic                               done,
    output logic [fbpa_pkg::STATUS_W-1:0]      status,
    output logic [fbpa_pkg::ADDR_W-1:0]        block_address,
    output logic [fbpa_pkg::INDEX_W-1:0]       slot_index,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_data
);

    fbpa_pkg::dp_cmd_t  cmd;
    fbpa_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .address       (address),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .block_address (block_address),
        .slot_index    (slot_index)
    );

    `FBPA_ASSERT_IMPL(a_done_after_busy, done, $past(busy))
    `FBPA_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
    `FBPA_ASSERT_IMPL(a_fail_zero_addr, done && (status != fbpa_pkg::ST_OK), block_address == '0)

endmodule
